// ----- design/mma_pkg.sv -----
// Shared constants and types for the multichannel moving average block.
// No dependencies; every other file of the block uses this package.
`default_nettype none

package mma_pkg;

  // Configuration of the filter.
  localparam int Channels   = 2;
  localparam int Window     = 8;
  localparam int SampleBits = 12;

  // Fixed field widths.
  localparam int ChannelBits = 1;
  localparam int AverageBits = 12;

  // Derived widths.
  localparam int ChanIdxBits  = (Channels > 1) ? $clog2(Channels) : 1;
  localparam int PosBits      = $clog2(Window);
  localparam int CountBits    = $clog2(Window + 1);
  localparam int SumBits      = SampleBits + $clog2(Window);
  localparam int RingDepth    = Channels * Window;
  localparam int RingAddrBits = $clog2(RingDepth);
  localparam int StepBits     = $clog2(SumBits + 1);

  // Request to the divider.
  typedef struct packed {
    logic                 start;
    logic [SumBits-1:0]   dividend;
    logic [CountBits-1:0] divisor;
  } div_req_t;

  // Response from the divider.
  typedef struct packed {
    logic               done;
    logic [SumBits-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ----- design/mma_if.sv -----
// Valid/ready channel interfaces for the sample input and the average output.
// Depends on mma_pkg for the field widths.
`default_nettype none

interface mma_in_if;
  logic                            valid;
  logic                            ready;
  logic [mma_pkg::ChannelBits-1:0] channel;
  logic [mma_pkg::SampleBits-1:0]  sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink   (input valid, input channel, input sample, output ready);
endinterface

interface mma_out_if;
  logic                            valid;
  logic                            ready;
  logic [mma_pkg::AverageBits-1:0] average;

  modport source (output valid, output average, input ready);
  modport sink   (input valid, input average, output ready);
endinterface

`default_nettype wire

// ----- design/mma_divider.sv -----
// Restoring divider, one quotient bit per cycle: running sum by sample count.
// Depends on mma_pkg for widths and the request/response structs.
`default_nettype none

module mma_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mma_pkg::div_req_t req_i,
  output mma_pkg::div_rsp_t rsp_o
);

  logic [mma_pkg::SumBits-1:0]   quot_q, quot_d;
  logic [mma_pkg::CountBits-1:0] rem_q, rem_d;
  logic [mma_pkg::CountBits-1:0] divisor_q, divisor_d;
  logic [mma_pkg::StepBits-1:0]  step_q, step_d;
  logic                          busy_q, busy_d;
  logic                          done_q, done_d;

  logic [mma_pkg::CountBits:0] trial;
  logic                        fits;

  // Shift next dividend bit into the partial remainder and try a subtract.
  assign trial = {rem_q, quot_q[mma_pkg::SumBits-1]};
  assign fits  = (trial >= {1'b0, divisor_q});

  always_comb begin
    quot_d    = quot_q;
    rem_d     = rem_q;
    divisor_d = divisor_q;
    step_d    = step_q;
    busy_d    = busy_q;
    done_d    = 1'b0;
    if (req_i.start) begin
      quot_d    = req_i.dividend;
      rem_d     = '0;
      divisor_d = req_i.divisor;
      step_d    = mma_pkg::StepBits'(mma_pkg::SumBits);
      busy_d    = 1'b1;
    end else if (busy_q) begin
      if (fits) begin
        rem_d = mma_pkg::CountBits'(trial - {1'b0, divisor_q});
      end else begin
        rem_d = trial[mma_pkg::CountBits-1:0];
      end
      quot_d = {quot_q[mma_pkg::SumBits-2:0], fits};
      step_d = step_q - 1'b1;
      if (step_q == mma_pkg::StepBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q    <= quot_d;
    rem_q     <= rem_d;
    divisor_q <= divisor_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quot_q;

endmodule

`default_nettype wire

// ----- design/multichannel_moving_average.sv -----
// Multichannel boxcar moving average: per-channel ring, running sum and mean.
// Depends on mma_pkg, mma_if (channel interfaces) and mma_divider.
// Flow: the input transfer reads the ring, the update state adds the sample and
//   starts the divider, which resolves one quotient bit per cycle; the mean then
//   goes to the output register. The block takes one sample at a time.
// Reset: asynchronous, active low; clears sums, ring positions and fill counts.
//   The ring memory itself is not cleared: slots not yet written count as zero.
`default_nettype none

module multichannel_moving_average (
  input  logic            clk_i,
  input  logic            rst_ni,
  mma_in_if.sink          in_i,
  mma_out_if.source       out_o
);

  // Sequencer states.
  typedef enum logic [3:0] {
    StIdle    = 4'b0001,  // ready for a sample; ring read issued on transfer
    StUpdate  = 4'b0010,  // update sum, ring, position, count; start divider
    StDivide  = 4'b0100,  // wait for the divider
    StDeliver = 4'b1000   // hand the mean to the output register
  } state_e;

  localparam logic [mma_pkg::PosBits-1:0]   LastPos   = mma_pkg::PosBits'(mma_pkg::Window - 1);
  localparam logic [mma_pkg::CountBits-1:0] WindowCnt = mma_pkg::CountBits'(mma_pkg::Window);

  state_e state_q, state_d;

  // Per-channel state, held in flops.
  logic [mma_pkg::SumBits-1:0]   sum_q  [mma_pkg::Channels];
  logic [mma_pkg::PosBits-1:0]   pos_q  [mma_pkg::Channels];
  logic [mma_pkg::CountBits-1:0] seen_q [mma_pkg::Channels];

  // Sample ring for all channels, addressed channel * Window + position.
  logic [mma_pkg::SampleBits-1:0] ring_mem [mma_pkg::RingDepth];
  logic [mma_pkg::SampleBits-1:0] rd_data_q;

  // Captured item.
  logic [mma_pkg::ChanIdxBits-1:0]  ch_q;
  logic [mma_pkg::SampleBits-1:0]   sample_q;
  logic [mma_pkg::RingAddrBits-1:0] addr_q;

  // Output register.
  logic                            out_valid_q, out_valid_d;
  logic [mma_pkg::AverageBits-1:0] avg_q;

  logic                             in_xfer;
  logic                             out_free;
  logic [mma_pkg::ChanIdxBits-1:0]  ch_in;
  logic [mma_pkg::RingAddrBits-1:0] rd_addr;
  logic                             warm;
  logic [mma_pkg::SampleBits-1:0]   old_smp;
  logic [mma_pkg::SumBits-1:0]      new_sum;
  logic [mma_pkg::PosBits-1:0]      new_pos;
  logic [mma_pkg::CountBits-1:0]    new_seen;
  logic                             load_out;

  mma_pkg::div_req_t div_req;
  mma_pkg::div_rsp_t div_rsp;

  assign in_i.ready = (state_q == StIdle);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  // Channel number reduced to the configured channel count.
  assign ch_in = (mma_pkg::Channels > 1) ? mma_pkg::ChanIdxBits'(in_i.channel) : '0;

  assign rd_addr = mma_pkg::RingAddrBits'(int'(ch_in) * mma_pkg::Window + int'(pos_q[ch_in]));

  // While a channel is still filling, the slot being replaced was never
  // written and counts as zero.
  assign warm    = (seen_q[ch_q] < WindowCnt);
  assign old_smp = warm ? '0 : rd_data_q;
  assign new_sum = sum_q[ch_q] - mma_pkg::SumBits'(old_smp) + mma_pkg::SumBits'(sample_q);
  assign new_pos = (pos_q[ch_q] == LastPos) ? '0 : pos_q[ch_q] + 1'b1;
  assign new_seen = warm ? seen_q[ch_q] + 1'b1 : seen_q[ch_q];

  assign div_req.start    = (state_q == StUpdate);
  assign div_req.dividend = new_sum;
  assign div_req.divisor  = new_seen;

  mma_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign load_out = (state_q == StDeliver) && out_free;

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_xfer) state_d = StUpdate;
      end
      StUpdate: begin
        state_d = StDivide;
      end
      StDivide: begin
        if (div_rsp.done) state_d = StDeliver;
      end
      StDeliver: begin
        if (out_free) state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Output valid: set when the mean is loaded, cleared on the output transfer.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_o.ready) out_valid_d = 1'b0;
    if (load_out) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      for (int i = 0; i < mma_pkg::Channels; i++) begin
        sum_q[i]  <= '0;
        pos_q[i]  <= '0;
        seen_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (state_q == StUpdate) begin
        sum_q[ch_q]  <= new_sum;
        pos_q[ch_q]  <= new_pos;
        seen_q[ch_q] <= new_seen;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      ch_q     <= ch_in;
      sample_q <= in_i.sample;
      addr_q   <= rd_addr;
    end
    if (load_out) begin
      avg_q <= mma_pkg::AverageBits'(div_rsp.quotient);
    end
  end

  // Ring memory: read the slot to be replaced on the input transfer,
  // write the new sample during the update cycle.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      rd_data_q <= ring_mem[rd_addr];
    end
    if (state_q == StUpdate) begin
      ring_mem[addr_q] <= sample_q;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.average = avg_q;

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for multichannel_moving_average: per-channel boxcar means.
// Depends on mma_pkg and the mma_in_if / mma_out_if channel interfaces.

module tb;
  import mma_pkg::*;

  localparam int ResultLatency = SumBits + 3;  // input transfer to result valid
  localparam int CycleLimit    = 500000;
  localparam int RandomSamples = 1800;
  localparam int MaxReports    = 10;
  localparam int HoldoffCycles = 300;

  // One queued sample for the sender; a drain entry makes the sender wait
  // until every pending average has come back.
  typedef struct packed {
    logic                   drain;
    logic [ChannelBits-1:0] channel;
    logic [SampleBits-1:0]  sample;
  } adc_xfer_t;

  typedef struct packed {
    logic [ChannelBits-1:0] channel;
    logic [AverageBits-1:0] average;
  } avg_expect_t;

  logic clk_i;
  logic rst_ni;

  mma_in_if  in_if ();
  mma_out_if out_if ();

  multichannel_moving_average dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // ---------------------------------------------------------------------------
  // Filter state as seen by the bench: ring, running sum, slot and fill count
  // per channel, all cleared at reset.
  // ---------------------------------------------------------------------------
  logic [SampleBits-1:0] hist_q [Channels][Window];
  logic [SumBits-1:0]    sum_q  [Channels];
  logic [PosBits-1:0]    pos_q  [Channels];
  logic [CountBits-1:0]  fill_q [Channels];

  adc_xfer_t   pending_samples [$];
  avg_expect_t avg_expected    [$];

  int unsigned failures;
  int unsigned samples_in;
  int unsigned averages_out;
  int unsigned chan_hits [Channels];
  int unsigned drains;
  int unsigned cycles;

  // Takes one sample into the channel and returns its new truncated mean.
  // The replaced slot is zero during warm-up, so the sum only grows then;
  // the divisor is the fill count, never zero after the new sample.
  function automatic logic [AverageBits-1:0] next_average(
    input logic [ChannelBits-1:0] ch_raw,
    input logic [SampleBits-1:0]  smp
  );
    int unsigned        ch;
    logic [SumBits-1:0] quo;
    ch = ch_raw % Channels;
    sum_q[ch] = sum_q[ch] - hist_q[ch][pos_q[ch]] + smp;
    hist_q[ch][pos_q[ch]] = smp;
    pos_q[ch] = (pos_q[ch] == Window - 1) ? '0 : pos_q[ch] + 1'b1;
    if (fill_q[ch] < Window) fill_q[ch] = fill_q[ch] + 1'b1;
    quo = sum_q[ch] / fill_q[ch];
    return quo[AverageBits-1:0];
  endfunction

  task automatic note_failure(input string msg);
    failures++;
    if (failures <= MaxReports) $display("tb: FAIL @%0t %s", $realtime, msg);
  endtask

  task automatic push_sample(input int unsigned ch, input int unsigned smp);
    adc_xfer_t x;
    x.drain   = 1'b0;
    x.channel = ch[ChannelBits-1:0];
    x.sample  = smp[SampleBits-1:0];
    pending_samples.push_back(x);
  endtask

  task automatic push_drain();
    adc_xfer_t x;
    x = '0;
    x.drain = 1'b1;
    pending_samples.push_back(x);
  endtask

  // Sample value by flavor: full range, near full scale, near zero, or the
  // two extremes; the near-scale flavors stress sum width and truncation.
  function automatic int unsigned pick_sample(input int unsigned flavor);
    int unsigned full;
    full = (1 << SampleBits) - 1;
    case (flavor)
      0:       return $urandom_range(0, full);
      1:       return full - $urandom_range(0, 15);
      2:       return $urandom_range(0, 15);
      default: return $urandom_range(0, 1) ? full : 0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Clock and reset. Reset is asserted once, at the start of the run.
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Sender: drains the pending queue in bursts of random length separated by
  // random gaps. The offered transfer is held until it is taken.
  // ---------------------------------------------------------------------------
  adc_xfer_t   nxt_sample;
  int unsigned gap_left;
  int unsigned burst_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid   <= 1'b0;
      in_if.channel <= '0;
      in_if.sample  <= '0;
      gap_left   = 0;
      burst_left = 1;
    end else if (!in_if.valid || in_if.ready) begin
      if (gap_left > 0) begin
        in_if.valid <= 1'b0;
        gap_left--;
      end else if (pending_samples.size() == 0) begin
        in_if.valid <= 1'b0;
      end else if (pending_samples[0].drain) begin
        // Only look at the expectation store once the last transfer has
        // settled, so a push from this same edge cannot be missed.
        in_if.valid <= 1'b0;
        if (!in_if.valid && avg_expected.size() == 0) begin
          void'(pending_samples.pop_front());
          drains++;
        end
      end else begin
        nxt_sample = pending_samples.pop_front();
        in_if.valid   <= 1'b1;
        in_if.channel <= nxt_sample.channel;
        in_if.sample  <= nxt_sample.sample;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready follows a pattern that changes at random intervals.
  // After the 150th and the 1100th average it holds off for a long stretch,
  // so the block backs up and stalls its input while the sender keeps trying.
  // ---------------------------------------------------------------------------
  int unsigned hold_left;
  int unsigned taken;
  int unsigned stall_mode;
  int unsigned mode_left;
  logic [2:0]  stall_phase;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      hold_left   <= 0;
      taken       <= 0;
      stall_mode  <= 0;
      mode_left   <= 0;
      stall_phase <= '0;
    end else begin
      if (out_if.valid && out_if.ready) taken <= taken + 1;
      stall_phase <= stall_phase + 1'b1;
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(50, 400);
      end else begin
        mode_left <= mode_left - 1;
      end

      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left    <= hold_left - 1;
      end else if (out_if.valid && out_if.ready && (taken == 149 || taken == 1099)) begin
        out_if.ready <= 1'b0;
        hold_left    <= HoldoffCycles;
      end else begin
        case (stall_mode)
          0:       out_if.ready <= 1'b1;
          1:       out_if.ready <= 1'($urandom_range(0, 1));
          2:       out_if.ready <= (stall_phase[1:0] != 2'd0);
          default: out_if.ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on every input transfer, checks every output transfer
  // against the oldest prediction. Values are the ones present before the edge.
  // ---------------------------------------------------------------------------
  avg_expect_t got_in;
  avg_expect_t oldest;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        got_in.channel = in_if.channel;
        got_in.average = next_average(in_if.channel, in_if.sample);
        avg_expected.push_back(got_in);
        samples_in++;
        chan_hits[in_if.channel % Channels]++;
      end
      if (out_if.valid && out_if.ready) begin
        averages_out++;
        if (avg_expected.size() == 0) begin
          note_failure($sformatf("unexpected average %0d", out_if.average));
        end else begin
          oldest = avg_expected.pop_front();
          if (out_if.average !== oldest.average)
            note_failure($sformatf("average #%0d (ch %0d): expected %0d, got %0d",
                                   averages_out, oldest.channel, oldest.average,
                                   out_if.average));
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("tb: timeout after %0d cycles, %0d averages outstanding",
               cycles, avg_expected.size());
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------------
  int unsigned full_scale;
  int unsigned n_rand;
  int unsigned seg_len;
  int unsigned seg_chan;
  int unsigned seg_kind;
  int unsigned seg_flavor;
  int unsigned seg_const;
  bit          mid_drain_done;

  initial begin
    avg_expect_t leftover;
    failures       = 0;
    samples_in     = 0;
    averages_out   = 0;
    drains         = 0;
    cycles         = 0;
    mid_drain_done = 1'b0;
    full_scale     = (1 << SampleBits) - 1;
    for (int c = 0; c < Channels; c++) begin
      sum_q[c]     = '0;
      pos_q[c]     = '0;
      fill_q[c]    = '0;
      chan_hits[c] = 0;
      for (int w = 0; w < Window; w++) hist_q[c][w] = '0;
    end

    // Directed: full-scale warm-up and wrap on channel 0 (largest sum),
    // a mixed warm-up on channel 1, then zeros pulling channel 0 down while
    // channel 1 fills past its window with full-scale samples.
    for (int i = 0; i < Window + 1; i++) push_sample(0, full_scale);
    push_sample(Channels - 1, 1);
    push_sample(Channels - 1, full_scale);
    push_sample(Channels - 1, 1 << (SampleBits - 1));
    push_sample(Channels - 1, 0);
    for (int i = 0; i < 3; i++) push_sample(0, 0);
    for (int i = 0; i < 6; i++) push_sample(Channels - 1, full_scale);
    push_drain();

    // Random: runs on one channel with a shared flavor, runs of one constant
    // value, and stretches of freely interleaved channels.
    n_rand = 0;
    while (n_rand < RandomSamples) begin
      seg_len    = $urandom_range(1, 24);
      seg_kind   = $urandom_range(0, 9);
      seg_chan   = $urandom_range(0, Channels - 1);
      seg_flavor = $urandom_range(0, 3);
      seg_const  = pick_sample(seg_flavor);
      for (int i = 0; i < seg_len; i++) begin
        if (seg_kind < 5) push_sample(seg_chan, pick_sample(seg_flavor));
        else if (seg_kind < 7) push_sample(seg_chan, seg_const);
        else push_sample($urandom_range(0, Channels - 1), pick_sample($urandom_range(0, 3)));
      end
      n_rand += seg_len;
      if (!mid_drain_done && n_rand >= RandomSamples / 2) begin
        push_drain();
        mid_drain_done = 1'b1;
      end
    end

    @(posedge rst_ni);
    @(negedge clk_i);
    while (pending_samples.size() != 0 || in_if.valid || avg_expected.size() != 0)
      @(negedge clk_i);
    repeat (4 * ResultLatency) @(negedge clk_i);

    while (avg_expected.size() != 0) begin
      leftover = avg_expected.pop_front();
      note_failure($sformatf("average %0d on ch %0d never arrived",
                             leftover.average, leftover.channel));
    end

    $display("tb: %0d samples (ch0 %0d, ch%0d %0d), %0d averages checked, %0d cycles",
             samples_in, chan_hits[0], Channels - 1, chan_hits[Channels - 1],
             averages_out, cycles);
    $display("tb: warm-up and wrap on both channels, %0d sender drains, %0d failures",
             drains, failures);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
